[design/rfp_pkg.sv]
// ----------------------------------------------------------------------------
// rfp_pkg: shared types and constants for the radar energy frame parser
// Frame markers, byte positions, status codes and the buffer size.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_LAST      = cnt_t'(BUFFER_BYTES - 1);
  localparam cnt_t MIN_FRAME     = cnt_t'(12);
  localparam cnt_t CHECK_FROM    = cnt_t'(8);
  localparam cnt_t POS_HEAD_END  = cnt_t'(4);
  localparam cnt_t POS_LEN_LO    = cnt_t'(4);
  localparam cnt_t POS_LEN_HI    = cnt_t'(5);
  localparam cnt_t POS_PRESENCE  = cnt_t'(6);
  localparam cnt_t POS_DIST_LO   = cnt_t'(7);
  localparam cnt_t POS_DIST_HI   = cnt_t'(8);

  localparam logic [31:0] FOOTER_WORD    = 32'hF8F7F6F5;
  localparam logic [31:0] HEADER_WORD    = 32'hF4F3F2F1;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd10;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_HEADER   = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] distance;
    logic [7:0]  presence;
    status_t     status;
  } result_t;

  typedef struct packed {
    cnt_t        count;
    logic [7:0]  held_presence;
    logic [15:0] held_distance;
  } trk_stat_t;

endpackage

[design/rfp_byte_reg.sv]
// ----------------------------------------------------------------------------
// rfp_byte_reg: input register
// Captures one received byte and holds it until the tracker takes it.
// ----------------------------------------------------------------------------
module rfp_byte_reg
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       adv,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] data_r;

  // refill in the same cycle the held byte moves on
  assign in_tready  = !valid_r || adv;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

[design/rfp_frame_track.sv]
// ----------------------------------------------------------------------------
// rfp_frame_track: frame position tracking and frame check
// Keeps the byte count, header, length and payload fields and the tail
// window; judges the frame when the footer shows up.
// ----------------------------------------------------------------------------
module rfp_frame_track
  import rfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] byte_data,
  output logic       res_valid,
  output result_t    res,
  output trk_stat_t  stat
);

  cnt_t        count_r,     count_nxt;
  logic [31:0] head_r,      head_nxt;
  logic [15:0] len_r,       len_nxt;
  logic [7:0]  spres_r,     spres_nxt;
  logic [15:0] sdist_r,     sdist_nxt;
  logic [31:0] tail_r,      tail_nxt;
  logic [7:0]  hpres_r,     hpres_nxt;
  logic [15:0] hdist_r,     hdist_nxt;
  cnt_t        cnt_inc;
  status_t     status;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    len_nxt   = len_r;
    spres_nxt = spres_r;
    sdist_nxt = sdist_r;
    tail_nxt  = tail_r;
    hpres_nxt = hpres_r;
    hdist_nxt = hdist_r;
    cnt_inc   = count_r + cnt_t'(1);
    status    = ST_OK;
    res_valid = 1'b0;

    if (count_r == CNT_LAST) begin
      // drop the byte and restart
      count_nxt = '0;
      status    = ST_OVERFLOW;
      res_valid = 1'b1;
    end else begin
      if (count_r < POS_HEAD_END) begin
        head_nxt = {head_r[23:0], byte_data};
      end else if (count_r == POS_LEN_LO) begin
        len_nxt = {len_r[15:8], byte_data};
      end else if (count_r == POS_LEN_HI) begin
        len_nxt = {byte_data, len_r[7:0]};
      end else if (count_r == POS_PRESENCE) begin
        spres_nxt = byte_data;
      end else if (count_r == POS_DIST_LO) begin
        sdist_nxt = {sdist_r[15:8], byte_data};
      end else if (count_r == POS_DIST_HI) begin
        sdist_nxt = {byte_data, sdist_r[7:0]};
      end
      tail_nxt  = {tail_r[23:0], byte_data};
      count_nxt = cnt_inc;

      if (cnt_inc >= CHECK_FROM && tail_nxt == FOOTER_WORD) begin
        if (head_nxt != HEADER_WORD) begin
          status = ST_BAD_HEADER;
        end else if (cnt_inc < MIN_FRAME) begin
          status = ST_TOO_SHORT;
        end else if (({1'b0, len_nxt} + FRAME_OVERHEAD) != 17'(cnt_inc)) begin
          status = ST_LEN_MISMATCH;
        end else begin
          status    = ST_OK;
          hpres_nxt = spres_nxt;
          hdist_nxt = sdist_nxt;
        end
        count_nxt = '0;
        res_valid = 1'b1;
      end
    end
  end

  assign res.status   = status;
  assign res.presence = hpres_nxt;
  assign res.distance = hdist_nxt;

  assign stat.count         = count_r;
  assign stat.held_presence = hpres_r;
  assign stat.held_distance = hdist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      len_r   <= '0;
      spres_r <= '0;
      sdist_r <= '0;
      tail_r  <= '0;
      hpres_r <= '0;
      hdist_r <= '0;
    end else if (adv) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      len_r   <= len_nxt;
      spres_r <= spres_nxt;
      sdist_r <= sdist_nxt;
      tail_r  <= tail_nxt;
      hpres_r <= hpres_nxt;
      hdist_r <= hdist_nxt;
    end
  end

endmodule

[design/rfp_out_reg.sv]
// ----------------------------------------------------------------------------
// rfp_out_reg: result register
// Holds one frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rfp_out_reg
  import rfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  result_t     res,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  logic    valid_r;
  result_t res_r;

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b0, res_r.distance, res_r.presence, res_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

[design/radar_energy_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// radar_energy_frame_parser_core: radar serial frame parser
// Tracks frame position in a byte stream, detects the footer, checks
// header, length and size, and reports status with the last good presence
// and distance.
//
//   channel   dir   width  contents (lowest bit first)
//   in_*      in      8    rx_byte[7:0]
//   out_*     out    32    frame_status[2:0], presence[10:3],
//                          distance_cm[26:11], zero[31:27]
//
// One byte per cycle sustained unless the result side stalls; a byte's result,
// if any, is loaded into the result register as the byte moves on.
// A byte that ends no frame and does not overflow gives no transaction.
// A stall on the result side holds the byte in the input register; a new
// byte is still taken in the cycle the held one moves on.
// Reset clears the count, windows and the held presence and distance.
// ----------------------------------------------------------------------------
module radar_energy_frame_parser_core
  import rfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // frame_status[2:0], presence[10:3],
                                  // distance_cm[26:11], zero[31:27]
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       adv;
  logic       res_valid;
  result_t    res;
  trk_stat_t  stat;

  // advance the held byte when the result register can take its outcome
  assign adv = byte_valid && (!out_tvalid || out_tready);

  rfp_byte_reg u_byte_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .adv        (adv),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  rfp_frame_track u_frame_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .byte_data (byte_data),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  rfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && res_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_LAST)
    else $error("byte count beyond buffer");

  a_count_clear : assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid |=> stat.count == '0)
    else $error("byte count not cleared after frame end");

  a_out_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:3] == stat.held_presence &&
                   out_tdata[26:11] == stat.held_distance)
    else $error("result fields differ from held values");

  a_no_load_stalled : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> !(byte_valid && $past(adv)))
    else $error("byte advanced while result stalled");

endmodule
